### rtl/core/extended_gcd_top_assert.svh
// Assertion macros for the extended GCD core.
// Needs clk and arst_n in the scope of each use.
`ifndef EXTENDED_GCD_TOP_ASSERT_SVH
`define EXTENDED_GCD_TOP_ASSERT_SVH

// same-cycle implication
`define EGCD_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("extended_gcd assertion failed");

// next-cycle implication
`define EGCD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("extended_gcd assertion failed");

`endif

### rtl/core/egcd_pkg.sv
// Shared types and constants for the extended GCD core.
// No dependencies.
package egcd_pkg;

	localparam int WIDTH   = 32;
	localparam int CW      = WIDTH + 1;
	localparam int CNT_W   = $clog2(WIDTH + 1);
	localparam int OPER_W  = 32;
	localparam int COEF_W  = 33;

	typedef logic [WIDTH-1:0] oper_t;
	typedef logic [CW-1:0]    coef_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} egcd_state_t;

	typedef struct packed {
		logic start;
	} step_ctrl_t;

	typedef struct packed {
		logic busy;
	} step_stat_t;

endpackage

### rtl/core/egcd_if.sv
// Valid/ready channel interfaces for operand and result beats.
// Depends on egcd_pkg.
interface egcd_in_if;
	logic                           valid;
	logic                           ready;
	logic [egcd_pkg::OPER_W-1:0]    a_value;
	logic [egcd_pkg::OPER_W-1:0]    b_value;

	modport source (output valid, a_value, b_value, input ready);
	modport sink (input valid, a_value, b_value, output ready);
endinterface

interface egcd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [egcd_pkg::OPER_W-1:0]           gcd_value;
	logic signed [egcd_pkg::COEF_W-1:0]    coef_a;
	logic signed [egcd_pkg::COEF_W-1:0]    coef_b;

	modport source (output valid, gcd_value, coef_a, coef_b, input ready);
	modport sink (input valid, gcd_value, coef_a, coef_b, output ready);
endinterface

### rtl/core/egcd_step.sv
// Shared serial unit: restoring division one quotient bit per cycle, with
// quotient-times-coefficient products accumulated from the same bits.
// Depends on egcd_pkg.
module egcd_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  egcd_pkg::step_ctrl_t ctrl,
	output egcd_pkg::step_stat_t stat,
	input  egcd_pkg::oper_t      dividend,
	input  egcd_pkg::oper_t      divisor,
	input  egcd_pkg::coef_t      s_mul,
	input  egcd_pkg::coef_t      t_mul,
	output egcd_pkg::oper_t      rem,
	output egcd_pkg::coef_t      s_prod,
	output egcd_pkg::coef_t      t_prod
);

	logic                       busy_q;
	logic [egcd_pkg::CNT_W-1:0] cnt_q;
	egcd_pkg::oper_t            rem_q;
	egcd_pkg::oper_t            quo_q;
	egcd_pkg::coef_t            ps_q;
	egcd_pkg::coef_t            pt_q;

	logic [egcd_pkg::WIDTH+1:0] diff;
	logic                       qbit;

	assign diff = {1'b0, rem_q, quo_q[egcd_pkg::WIDTH-1]} - {2'b00, divisor};
	assign qbit = ~diff[egcd_pkg::WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= egcd_pkg::CNT_W'(egcd_pkg::WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == egcd_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			ps_q  <= '0;
			pt_q  <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[egcd_pkg::WIDTH-1:0]
			              : {rem_q[egcd_pkg::WIDTH-2:0], quo_q[egcd_pkg::WIDTH-1]};
			quo_q <= {quo_q[egcd_pkg::WIDTH-2:0], qbit};
			ps_q  <= {ps_q[egcd_pkg::CW-2:0], 1'b0} + (qbit ? s_mul : '0);
			pt_q  <= {pt_q[egcd_pkg::CW-2:0], 1'b0} + (qbit ? t_mul : '0);
		end
	end

	assign stat.busy = busy_q;
	assign rem       = rem_q;
	assign s_prod    = ps_q;
	assign t_prod    = pt_q;

endmodule

### rtl/core/extended_gcd_top.sv
// Top level of the extended GCD core: sequencer, remainder and coefficient
// registers, result register. Depends on egcd_pkg, egcd_if, egcd_step and
// extended_gcd_top_assert.svh.
//
//   channel    dir   beat carries
//   operands   in    a_value, b_value
//   result     out   gcd_value, coef_a, coef_b
//
// A quotient step runs through the zero test, the divide/multiply iterations
// until the unit is seen idle, and the coefficient update. A pair of operands
// needs up to about 46 quotient steps at WIDTH 32; operands are taken again
// from the cycle in which its result becomes valid.
// Reset clears the sequencer and result valid. A stalled result holds the
// block in its final state; operands are taken only when idle.
module extended_gcd_top (
	input logic       clk,
	input logic       arst_n,
	egcd_in_if.sink   operands,
	egcd_out_if.source result
);

	egcd_pkg::egcd_state_t state_q, state_d;
	egcd_pkg::step_ctrl_t  unit_ctrl;
	egcd_pkg::step_stat_t  unit_stat;

	egcd_pkg::oper_t r0_q, r1_q, rem;
	egcd_pkg::coef_t s0_q, s1_q, t0_q, t1_q, s_prod, t_prod;

	logic                                out_valid_q;
	logic [egcd_pkg::OPER_W-1:0]         gcd_q;
	logic [egcd_pkg::COEF_W-1:0]         ca_q, cb_q;

	logic accept, load_out;

	egcd_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (unit_ctrl),
		.stat     (unit_stat),
		.dividend (r0_q),
		.divisor  (r1_q),
		.s_mul    (s1_q),
		.t_mul    (t1_q),
		.rem      (rem),
		.s_prod   (s_prod),
		.t_prod   (t_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		unit_ctrl.start = 1'b0;
		operands.ready  = 1'b0;
		load_out        = 1'b0;
		case (state_q)
			egcd_pkg::ST_IDLE: begin
				operands.ready = 1'b1;
				if (operands.valid) begin
					state_d = egcd_pkg::ST_TEST;
				end
			end
			egcd_pkg::ST_TEST: begin
				if (r1_q == '0) begin
					state_d = egcd_pkg::ST_FIN;
				end else begin
					unit_ctrl.start = 1'b1;
					state_d         = egcd_pkg::ST_DIV;
				end
			end
			egcd_pkg::ST_DIV: begin
				if (!unit_stat.busy) begin
					state_d = egcd_pkg::ST_UPD;
				end
			end
			egcd_pkg::ST_UPD: begin
				state_d = egcd_pkg::ST_TEST;
			end
			egcd_pkg::ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = egcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = egcd_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = operands.valid && operands.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			r0_q <= egcd_pkg::WIDTH'(operands.a_value);
			r1_q <= egcd_pkg::WIDTH'(operands.b_value);
			s0_q <= egcd_pkg::CW'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= egcd_pkg::CW'(1);
		end else if (state_q == egcd_pkg::ST_UPD) begin
			r0_q <= r1_q;
			r1_q <= rem;
			s0_q <= s1_q;
			s1_q <= s0_q - s_prod;
			t0_q <= t1_q;
			t1_q <= t0_q - t_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			gcd_q <= egcd_pkg::OPER_W'(r0_q);
			ca_q  <= egcd_pkg::COEF_W'(s0_q);
			cb_q  <= egcd_pkg::COEF_W'(t0_q);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.gcd_value = gcd_q;
	assign result.coef_a    = ca_q;
	assign result.coef_b    = cb_q;

`include "extended_gcd_top_assert.svh"

	`EGCD_ASSERT_NEXT(a_accept_busy, accept, !operands.ready)
	`EGCD_ASSERT_NOW(a_unit_in_div, unit_stat.busy, state_q == egcd_pkg::ST_DIV)
	`EGCD_ASSERT_NOW(a_rem_below, state_q == egcd_pkg::ST_UPD, rem < r1_q)
	`EGCD_ASSERT_NOW(a_load_free, load_out, !out_valid_q || result.ready)

endmodule
